// ===== rtl/fo_iir_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the first-order IIR filter.
// Holds form codes, register indexes, sequencer control types and saturation.
// No dependencies.
package fo_iir_pkg;

  localparam int COEF_W  = 24;
  localparam int STATE_W = 32;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = STATE_W + COEF_W;
  localparam int STEP_W  = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

  localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd1048576;

  localparam logic signed [ACC_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    FORM_DF1  = 2'd0,
    FORM_DF2  = 2'd1,
    FORM_DF1T = 2'd2,
    FORM_DF2T = 2'd3
  } form_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_B0   = 2'd1,
    REG_B1   = 2'd2,
    REG_A1   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    A_X,
    A_WD,
    A_XD,
    A_YD,
    A_W,
    A_Y
  } asel_t;

  typedef enum logic [1:0] {
    B_B0,
    B_B1,
    B_A1
  } bsel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SHX,
    ACC_SHXD
  } acc_op_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_WSUM,
    CAP_W,
    CAP_Y,
    CAP_XN
  } cap_t;

  typedef struct packed {
    asel_t   a_sel;
    bsel_t   b_sel;
    acc_op_t acc_op;
    cap_t    cap;
    logic    last;
  } ctl_t;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[STATE_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/first_order_iir_multiform_top.sv =====
`timescale 1ns / 1ps
// Multichannel first-order IIR filter, four selectable structures.
// Depends on fo_iir_pkg.
//
// Usage: an item (channel, sample) enters on the in_ valid/ready channel and
// one filtered item (channel, sample) leaves on the out_ valid/ready channel.
// Per-channel delay values live in one synchronous memory, read at accept
// and written back once the item is finished. One 32x24 multiplier is
// shared by the three products of an item, with the round and saturate
// steps between dependent products.
// in_ready is high only while the sequencer is idle, so a new item is taken
// only once the last one has finished. A finished item waits in the output
// register; if it is still there when the next one finishes, the sequencer
// holds until out_ready. Reset sets direct form II transposed, b0 = 1.0,
// b1 = a1 = 0 and clears all delay values through per-channel valid bits;
// a write of form_mode clears them the same way. Channels at or above
// CHANNELS give sample 0 and leave the state alone. Registers sit on an
// APB port at 4*index.
module first_order_iir_multiform_top
  import fo_iir_pkg::*;
#(
  parameter int CHANNELS       = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_channel_out,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WORD_W = 3 * STATE_W;
  localparam logic signed [ACC_W-1:0] RND_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SB_MAX   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SB_MIN   = -SB_MAX - 64'sd1;

  // configuration
  form_t                     mode_r;
  logic signed [COEF_W-1:0]  coef_b0_r;
  logic signed [COEF_W-1:0]  coef_b1_r;
  logic signed [COEF_W-1:0]  coef_a1_r;
  reg_idx_t                  reg_idx;
  logic                      cfg_wr;
  logic                      cfg_mode_wr;

  // sequencer
  state_t                    state_r;
  state_t                    state_nxt;
  logic [STEP_W-1:0]         step_r;
  logic [STEP_W-1:0]         step_nxt;
  ctl_t                      ctl;
  logic                      accept;
  logic                      fin_go;
  logic                      mem_we;

  // memory and valid bits
  logic [WORD_W-1:0]         mem [CHANNELS];
  logic [WORD_W-1:0]         rd_r;
  logic                      rdv_r;
  logic [CHANNELS-1:0]       vld_r;
  logic [CH_AW-1:0]          in_idx;
  logic [CH_AW-1:0]          ch_idx;
  logic                      in_oor;
  logic [WORD_W-1:0]         wr_data;

  // datapath
  logic [2:0]                ch_r;
  logic                      oor_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [STATE_W-1:0] x32;
  logic signed [STATE_W-1:0] wd_q;
  logic signed [STATE_W-1:0] xd_q;
  logic signed [STATE_W-1:0] yd_q;
  logic signed [STATE_W-1:0] mul_a;
  logic signed [COEF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   rnd_val;
  logic signed [STATE_W-1:0] rnd_sat;
  logic signed [STATE_W-1:0] w_r;
  logic signed [STATE_W-1:0] y_r;
  logic signed [STATE_W-1:0] xn_r;
  logic signed [STATE_W-1:0] wd_new;
  logic signed [STATE_W-1:0] xd_new;
  logic signed [STATE_W-1:0] yd_new;
  logic signed [SAMPLE_BITS-1:0] y_out;

  // output register
  logic                      out_valid_r;
  logic [2:0]                out_channel_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  assign pready      = 1'b1;
  assign reg_idx     = reg_idx_t'(paddr[3:2]);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_mode_wr = cfg_wr && (reg_idx == REG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= FORM_DF2T;
      coef_b0_r <= B0_RESET;
      coef_b1_r <= '0;
      coef_a1_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE: mode_r    <= form_t'(pwdata[1:0]);
        REG_B0:   coef_b0_r <= pwdata[COEF_W-1:0];
        REG_B1:   coef_b1_r <= pwdata[COEF_W-1:0];
        REG_A1:   coef_a1_r <= pwdata[COEF_W-1:0];
        default:  mode_r    <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE: prdata = {30'd0, mode_r};
      REG_B0:   prdata = {8'd0, coef_b0_r};
      REG_B1:   prdata = {8'd0, coef_b1_r};
      REG_A1:   prdata = {8'd0, coef_a1_r};
      default:  prdata = '0;
    endcase
  end

  // sequencer
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign mem_we   = fin_go && !oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ctl.last) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // step schedule per form
  always_comb begin
    ctl = '{a_sel: A_X, b_sel: B_B0, acc_op: ACC_HOLD, cap: CAP_NONE, last: 1'b0};
    unique case (mode_r)
      FORM_DF1: begin
        case (step_r)
          3'd0: ctl.a_sel = A_X;
          3'd1: begin
            ctl.a_sel = A_XD; ctl.b_sel = B_B1; ctl.acc_op = ACC_LOAD;
          end
          3'd2: begin
            ctl.a_sel = A_YD; ctl.b_sel = B_A1; ctl.acc_op = ACC_ADD;
          end
          3'd3: ctl.acc_op = ACC_ADD;
          default: begin
            ctl.cap = CAP_Y; ctl.last = 1'b1;
          end
        endcase
      end
      FORM_DF2: begin
        case (step_r)
          3'd0: begin
            ctl.a_sel = A_WD; ctl.b_sel = B_A1;
          end
          3'd1: begin
            ctl.a_sel = A_WD; ctl.b_sel = B_B1; ctl.acc_op = ACC_SHX;
          end
          3'd2: begin
            ctl.cap = CAP_W; ctl.acc_op = ACC_LOAD;
          end
          3'd3: begin
            ctl.a_sel = A_W; ctl.b_sel = B_B0;
          end
          3'd4: ctl.acc_op = ACC_ADD;
          default: begin
            ctl.cap = CAP_Y; ctl.last = 1'b1;
          end
        endcase
      end
      FORM_DF1T: begin
        case (step_r)
          3'd0: ctl.cap = CAP_WSUM;
          3'd1: begin
            ctl.a_sel = A_W; ctl.b_sel = B_B0;
          end
          3'd2: begin
            ctl.a_sel = A_W; ctl.b_sel = B_B1; ctl.acc_op = ACC_SHXD;
          end
          3'd3: begin
            ctl.a_sel = A_W; ctl.b_sel = B_A1; ctl.acc_op = ACC_LOAD; ctl.cap = CAP_Y;
          end
          3'd4: begin
            ctl.acc_op = ACC_LOAD; ctl.cap = CAP_XN;
          end
          default: begin
            ctl.cap = CAP_W; ctl.last = 1'b1;
          end
        endcase
      end
      FORM_DF2T: begin
        case (step_r)
          3'd0: ctl.a_sel = A_X;
          3'd1: begin
            ctl.a_sel = A_X; ctl.b_sel = B_B1; ctl.acc_op = ACC_SHXD;
          end
          3'd2: begin
            ctl.cap = CAP_Y; ctl.acc_op = ACC_LOAD;
          end
          3'd3: begin
            ctl.a_sel = A_Y; ctl.b_sel = B_A1;
          end
          3'd4: ctl.acc_op = ACC_ADD;
          default: begin
            ctl.cap = CAP_XN; ctl.last = 1'b1;
          end
        endcase
      end
      default: ctl.last = 1'b1;
    endcase
  end

  // delay memory
  assign in_idx  = CH_AW'(in_channel);
  assign ch_idx  = CH_AW'(ch_r);
  assign in_oor  = (32'(in_channel) >= CHANNELS);
  assign wr_data = {wd_new, xd_new, yd_new};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ch_idx] <= wr_data;
    end
    if (accept) begin
      rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_mode_wr) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[ch_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdv_r <= in_oor ? 1'b0 : vld_r[in_idx];
      ch_r  <= in_channel;
      oor_r <= in_oor;
      x_r   <= in_sample_in;
    end
  end

  assign x32  = STATE_W'(x_r);
  assign wd_q = rdv_r ? rd_r[3*STATE_W-1:2*STATE_W] : '0;
  assign xd_q = rdv_r ? rd_r[2*STATE_W-1:STATE_W]   : '0;
  assign yd_q = rdv_r ? rd_r[STATE_W-1:0]           : '0;

  // shared multiplier and accumulator
  always_comb begin
    case (ctl.a_sel)
      A_X:     mul_a = x32;
      A_WD:    mul_a = wd_q;
      A_XD:    mul_a = xd_q;
      A_YD:    mul_a = yd_q;
      A_W:     mul_a = w_r;
      A_Y:     mul_a = y_r;
      default: mul_a = x32;
    endcase
    case (ctl.b_sel)
      B_B0:    mul_b = coef_b0_r;
      B_B1:    mul_b = coef_b1_r;
      B_A1:    mul_b = coef_a1_r;
      default: mul_b = coef_b0_r;
    endcase
    case (ctl.acc_op)
      ACC_ADD:  acc_base = acc_r;
      ACC_SHX:  acc_base = ACC_W'(x32) <<< COEF_FRAC_BITS;
      ACC_SHXD: acc_base = ACC_W'(xd_q) <<< COEF_FRAC_BITS;
      default:  acc_base = '0;
    endcase
  end

  assign rnd_val = (acc_r + RND_HALF) >>> COEF_FRAC_BITS;
  assign rnd_sat = sat32(rnd_val);

  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      p_r <= mul_a * mul_b;
      if (ctl.acc_op != ACC_HOLD) begin
        acc_r <= acc_base + ACC_W'(p_r);
      end
      case (ctl.cap)
        CAP_WSUM: w_r  <= sat32(ACC_W'(x32) + ACC_W'(wd_q));
        CAP_W:    w_r  <= rnd_sat;
        CAP_Y:    y_r  <= rnd_sat;
        CAP_XN:   xn_r <= rnd_sat;
        default:  w_r  <= w_r;
      endcase
    end
  end

  // write-back values
  always_comb begin
    wd_new = wd_q;
    xd_new = xd_q;
    yd_new = yd_q;
    unique case (mode_r)
      FORM_DF1: begin
        xd_new = x32;
        yd_new = y_r;
      end
      FORM_DF2:  wd_new = w_r;
      FORM_DF1T: begin
        wd_new = w_r;
        xd_new = xn_r;
      end
      FORM_DF2T: xd_new = xn_r;
      default:   wd_new = wd_q;
    endcase
  end

  always_comb begin
    if (ACC_W'(y_r) > SB_MAX) begin
      y_out = SB_MAX[SAMPLE_BITS-1:0];
    end else if (ACC_W'(y_r) < SB_MIN) begin
      y_out = SB_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_out = y_r[SAMPLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_channel_r <= ch_r;
      out_sample_r  <= oor_r ? '0 : y_out;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_channel_r;
  assign out_sample_out  = out_sample_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN) && (step_r == '0))
    else $error("accepted item did not start at step zero");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= LAST_STEP))
    else $error("step counter ran past the last step");

  a_mode_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_mode_wr |=> (vld_r == '0))
    else $error("form write did not clear delay state");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished item not loaded into output register");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && oor_r) |=> (out_sample_r == '0))
    else $error("out of range channel gave nonzero sample");

endmodule
